// ----- sv/dpcr_pkg.sv -----
// Shared constants, types and saturation helpers for the disc pair collision resolver.
package dpcr_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int EXTRA_BITS = 8;
  localparam int POS_W      = 20;
  localparam int VEL_W      = 16;
  localparam int RAD_W      = 15;
  localparam int DATA_W     = 4 * POS_W + 4 * VEL_W;
  localparam int USER_W     = 3;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 15'd6400;

  // square root unit: floor(sqrt(x)) of a 48-bit value, one root bit per stage
  localparam int SQ_IN_W  = 48;
  localparam int SQRT_W   = 24;
  localparam int SQ_REM_W = SQ_IN_W + 1;
  localparam int SQRT_LAT = SQRT_W;

  // rounding divider: one setup stage, then one quotient bit per stage
  localparam int DIV_MAG_W = 50;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_Q_W   = 19;
  localparam int DIV_REM_W = 53;
  localparam int DIV_DD_W  = DIV_DEN_W + 1;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  typedef struct packed {
    logic signed [POS_W-1:0] first_pos_x;
    logic signed [POS_W-1:0] first_pos_y;
    logic signed [POS_W-1:0] second_pos_x;
    logic signed [POS_W-1:0] second_pos_y;
    logic signed [VEL_W-1:0] first_vel_x;
    logic signed [VEL_W-1:0] first_vel_y;
    logic signed [VEL_W-1:0] second_vel_x;
    logic signed [VEL_W-1:0] second_vel_y;
  } pair_t;

  // side data that travels with a pair through the arithmetic units
  typedef struct packed {
    pair_t               pair;
    logic signed [16:0]  dx;
    logic signed [16:0]  dy;
    logic signed [35:0]  dot;
    logic [31:0]         d2;
    logic [RAD_W:0]      min_d;
    logic                contact;
    logic                coin;
    logic                imp;
  } side_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic [POS_W-1:0] r;
    if ((v[POS_W+1:POS_W-1] == 3'b000) || (v[POS_W+1:POS_W-1] == 3'b111)) begin
      r = v[POS_W-1:0];
    end else if (v[POS_W+1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VEL_W+4:0] v);
    logic [VEL_W-1:0] r;
    if ((v[VEL_W+4:VEL_W-1] == '0) || (v[VEL_W+4:VEL_W-1] == '1)) begin
      r = v[VEL_W-1:0];
    end else if (v[VEL_W+4]) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- sv/dpcr_isqrt.sv -----
// Pipelined integer square root, one result bit resolved per register stage.
module dpcr_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dpcr_pkg::SQ_IN_W-1:0] x,
  output logic [dpcr_pkg::SQRT_W-1:0]  root
);
  import dpcr_pkg::*;

  logic [SQ_REM_W-1:0] rem_q  [SQRT_W];
  logic [SQRT_W-1:0]   root_q [SQRT_W];

  for (genvar i = 0; i < SQRT_W; i++) begin : g_st
    localparam int B = SQRT_W - 1 - i;
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_REM_W-1:0] trial;
    logic [SQRT_W-1:0]   root_in;

    if (i == 0) begin : g_first
      assign rem_in  = SQ_REM_W'(x);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // (r + 2^B)^2 - r^2
    assign trial = (SQ_REM_W'(root_in) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (SQRT_W'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign root = root_q[SQRT_W-1];

endmodule

// ----- sv/dpcr_rdiv.sv -----
// Pipelined restoring divider giving mag/den rounded to nearest, ties away from zero.
module dpcr_rdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dpcr_pkg::DIV_MAG_W-1:0] mag,
  input  logic [dpcr_pkg::DIV_DEN_W-1:0] den,
  output logic [dpcr_pkg::DIV_Q_W-1:0]   q
);
  import dpcr_pkg::*;

  logic [DIV_REM_W-1:0] rem0;
  logic [DIV_DD_W-1:0]  dd0;
  logic [DIV_REM_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_DD_W-1:0]  dd_q  [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_q   [DIV_Q_W];

  // setup: (2*mag + den) / (2*den)
  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= (DIV_REM_W'(mag) << 1) + DIV_REM_W'(den);
      dd0  <= {den, 1'b0};
    end
  end

  for (genvar i = 0; i < DIV_Q_W; i++) begin : g_st
    localparam int B = DIV_Q_W - 1 - i;
    logic [DIV_REM_W-1:0] rem_in;
    logic [DIV_REM_W-1:0] trial;
    logic [DIV_DD_W-1:0]  dd_in;
    logic [DIV_Q_W-1:0]   q_in;

    if (i == 0) begin : g_first
      assign rem_in = rem0;
      assign dd_in  = dd0;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dd_in  = dd_q[i-1];
      assign q_in   = q_q[i-1];
    end

    assign trial = DIV_REM_W'(dd_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dd_q[i] <= dd_in;
        if (rem_in >= trial) begin
          rem_q[i] <= rem_in - trial;
          q_q[i]   <= q_in | (DIV_Q_W'(1) << B);
        end else begin
          rem_q[i] <= rem_in;
          q_q[i]   <= q_in;
        end
      end
    end
  end

  assign q = q_q[DIV_Q_W-1];

endmodule

// ----- sv/disc_pair_collision_resolve_core.sv -----
// Top level of the equal-mass disc pair collision resolver stream pipeline.
//
// Takes one disc pair per cycle while the skid stage is free and returns one
// result per pair, in order: three stages form the differences, squares,
// squared distance and normal dot product; 24 stages of a bit-per-stage
// square root give the distance with 8 extra fraction bits; three stages form
// the overlap and the division numerators; four parallel 20-stage rounding
// dividers give the separation and impulse components; one output register
// with a skid stage holds the saturated result. The whole pipeline advances
// together, and it keeps accepting pairs while a finished result waits in the
// output register; it holds only once the skid stage is also full. Pairs
// closer than twice the radius are pushed apart, approaching pairs exchange
// their normal velocity, coincident centres are flagged and pass through. The
// radius is written on the cfg channel, which is always ready; write it only
// while the pipeline is empty. Reset radius is 6400 (25.0 pixels in Q7.8).
module disc_pair_collision_resolve_core (
  input  logic                        clk,
  input  logic                        rst,
  // radius write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dpcr_pkg::RAD_W-1:0]  cfg_data,
  // pair input; tdata from bit 0: first_pos_x, first_pos_y, second_pos_x,
  // second_pos_y, first_vel_x, first_vel_y, second_vel_x, second_vel_y
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dpcr_pkg::DATA_W-1:0] s_tdata,
  // result output; tdata from bit 0: new_first_pos_x, new_first_pos_y,
  // new_second_pos_x, new_second_pos_y, new_first_vel_x, new_first_vel_y,
  // new_second_vel_x, new_second_vel_y
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dpcr_pkg::DATA_W-1:0] m_tdata,
  // tuser from bit 0: in_contact, impulse_applied, coincident
  output logic [dpcr_pkg::USER_W-1:0] m_tuser
);
  import dpcr_pkg::*;

  logic [RAD_W-1:0] disc_radius;
  logic             en;
  logic             skid_valid;

  // radius register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      disc_radius <= cfg_data;
    end
  end

  // the pipeline advances as one while the skid stage is free
  assign en       = !skid_valid;
  assign s_tready = en;

  pair_t in_pair;
  assign in_pair.first_pos_x  = s_tdata[19:0];
  assign in_pair.first_pos_y  = s_tdata[39:20];
  assign in_pair.second_pos_x = s_tdata[59:40];
  assign in_pair.second_pos_y = s_tdata[79:60];
  assign in_pair.first_vel_x  = s_tdata[95:80];
  assign in_pair.first_vel_y  = s_tdata[111:96];
  assign in_pair.second_vel_x = s_tdata[127:112];
  assign in_pair.second_vel_y = s_tdata[143:128];

  // ---------------- stage 1: differences ----------------
  logic               v1;
  pair_t              pair1;
  logic signed [20:0] dx1, dy1;
  logic signed [16:0] dvx1, dvy1;
  logic [RAD_W:0]     mind1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair1 <= in_pair;
      dx1   <= 21'(in_pair.second_pos_x) - 21'(in_pair.first_pos_x);
      dy1   <= 21'(in_pair.second_pos_y) - 21'(in_pair.first_pos_y);
      dvx1  <= 17'(in_pair.first_vel_x) - 17'(in_pair.second_vel_x);
      dvy1  <= 17'(in_pair.first_vel_y) - 17'(in_pair.second_vel_y);
      mind1 <= {disc_radius, 1'b0};
    end
  end

  // ---------------- stage 2: products ----------------
  logic               v2;
  pair_t              pair2;
  logic signed [20:0] dx2, dy2;
  logic signed [41:0] dxx2, dyy2;
  logic signed [38:0] px2, py2;
  logic [31:0]        minsq2;
  logic [RAD_W:0]     mind2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair2  <= pair1;
      dx2    <= dx1;
      dy2    <= dy1;
      dxx2   <= 42'(dx1) * 42'(dx1);
      dyy2   <= 42'(dy1) * 42'(dy1);
      px2    <= 39'(dvx1) * 39'(dx1);
      py2    <= 39'(dvy1) * 39'(dy1);
      minsq2 <= 32'(mind1) * 32'(mind1);
      mind2  <= mind1;
    end
  end

  // ---------------- stage 3: distance squared, dot, contact test ----------------
  logic        v3;
  side_t       s3;
  logic [41:0] d2_sum;
  logic signed [38:0] dot_sum;

  assign d2_sum  = $unsigned(dxx2 + dyy2);
  assign dot_sum = px2 + py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  // in contact the squared distance stays below 2^32 and each difference below 2^16
  always_ff @(posedge clk) begin
    if (en) begin
      s3.pair    <= pair2;
      s3.dx      <= dx2[16:0];
      s3.dy      <= dy2[16:0];
      s3.dot     <= dot_sum[35:0];
      s3.d2      <= d2_sum[31:0];
      s3.min_d   <= mind2;
      s3.coin    <= (d2_sum == '0);
      s3.contact <= (d2_sum != '0) && (d2_sum < {10'b0, minsq2});
      s3.imp     <= 1'b0;
    end
  end

  // ---------------- square root span ----------------
  logic [SQ_IN_W-1:0] sq_x;
  logic [SQRT_W-1:0]  sq_root;
  side_t              sq_side [SQRT_LAT];
  logic [SQRT_LAT-1:0] sq_v;

  assign sq_x = s3.contact ? {s3.d2, 16'b0} : '0;

  dpcr_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (sq_x),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (en) begin
      sq_v <= {sq_v[SQRT_LAT-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= s3;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // ---------------- post 1: overlap, magnitudes, approach test ----------------
  side_t       ps1;
  logic        pv1;
  logic [23:0] ov1;
  logic [23:0] root1;
  logic [15:0] adx1, ady1;
  logic [33:0] adot1;
  side_t       sq_out;
  logic        approach;
  side_t       sq_tag;

  assign sq_out   = sq_side[SQRT_LAT-1];
  assign approach = sq_out.contact && (sq_out.dot > 0);

  // mark the approach decision on the side data
  always_comb begin
    sq_tag     = sq_out;
    sq_tag.imp = approach;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
    end else if (en) begin
      pv1 <= sq_v[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps1       <= sq_tag;
      ov1       <= {sq_out.min_d, 8'b0} - sq_root;
      root1     <= sq_root;
      adx1      <= sq_out.dx[16] ? 16'(-sq_out.dx) : sq_out.dx[15:0];
      ady1      <= sq_out.dy[16] ? 16'(-sq_out.dy) : sq_out.dy[15:0];
      adot1     <= approach ? sq_out.dot[33:0] : '0;
    end
  end

  // ---------------- post 2: numerator products ----------------
  side_t       ps2;
  logic        pv2;
  logic [23:0] root2;
  logic [39:0] nx2, ny2;
  logic [32:0] lx2, hx2, ly2, hy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv2 <= 1'b0;
    end else if (en) begin
      pv2 <= pv1;
    end
  end

  // split the dot magnitude so each product stays near 16 by 17 bits
  always_ff @(posedge clk) begin
    if (en) begin
      ps2   <= ps1;
      root2 <= root1;
      nx2   <= 40'(adx1) * 40'(ov1);
      ny2   <= 40'(ady1) * 40'(ov1);
      lx2   <= 33'(adx1) * 33'(adot1[16:0]);
      hx2   <= 33'(adx1) * 33'(adot1[33:17]);
      ly2   <= 33'(ady1) * 33'(adot1[16:0]);
      hy2   <= 33'(ady1) * 33'(adot1[33:17]);
    end
  end

  // ---------------- post 3: numerators and denominators ----------------
  side_t                ps3;
  logic                 pv3;
  logic [DIV_MAG_W-1:0] nx3, ny3, nix3, niy3;
  logic [DIV_DEN_W-1:0] den_s3, den_i3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv3 <= 1'b0;
    end else if (en) begin
      pv3 <= pv2;
    end
  end

  // out of contact the quotient is dropped: feed a harmless divisor of one
  always_ff @(posedge clk) begin
    if (en) begin
      ps3    <= ps2;
      nx3    <= DIV_MAG_W'(nx2);
      ny3    <= DIV_MAG_W'(ny2);
      nix3   <= DIV_MAG_W'(lx2) + (DIV_MAG_W'(hx2) << 17);
      niy3   <= DIV_MAG_W'(ly2) + (DIV_MAG_W'(hy2) << 17);
      den_s3 <= ps2.contact ? {7'b0, root2, 1'b0} : DIV_DEN_W'(1);
      den_i3 <= ps2.contact ? ps2.d2 : DIV_DEN_W'(1);
    end
  end

  // ---------------- divider span ----------------
  logic [DIV_Q_W-1:0] qsx, qsy, qix, qiy;
  side_t              dv_side [DIV_LAT];
  logic [DIV_LAT-1:0] dv_v;

  dpcr_rdiv u_div_sx (.clk(clk), .en(en), .mag(nx3),  .den(den_s3), .q(qsx));
  dpcr_rdiv u_div_sy (.clk(clk), .en(en), .mag(ny3),  .den(den_s3), .q(qsy));
  dpcr_rdiv u_div_ix (.clk(clk), .en(en), .mag(nix3), .den(den_i3), .q(qix));
  dpcr_rdiv u_div_iy (.clk(clk), .en(en), .mag(niy3), .den(den_i3), .q(qiy));

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (en) begin
      dv_v <= {dv_v[DIV_LAT-2:0], pv3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= ps3;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // ---------------- final: apply signs, move, saturate ----------------
  side_t              fs;
  logic signed [21:0] sx, sy;
  logic signed [20:0] ix, iy;
  logic [DATA_W-1:0]  res_data;
  logic [USER_W-1:0]  res_user;
  logic               push;
  pair_t              np;

  assign fs   = dv_side[DIV_LAT-1];
  assign push = en && dv_v[DIV_LAT-1];

  // component signs follow the normal since overlap and approach are positive
  assign sx = fs.dx[16] ? -$signed({3'b0, qsx}) : $signed({3'b0, qsx});
  assign sy = fs.dy[16] ? -$signed({3'b0, qsy}) : $signed({3'b0, qsy});
  assign ix = fs.dx[16] ? -$signed({2'b0, qix}) : $signed({2'b0, qix});
  assign iy = fs.dy[16] ? -$signed({2'b0, qiy}) : $signed({2'b0, qiy});

  always_comb begin
    np = fs.pair;
    if (fs.contact) begin
      np.first_pos_x  = sat_pos(22'(fs.pair.first_pos_x) - sx);
      np.first_pos_y  = sat_pos(22'(fs.pair.first_pos_y) - sy);
      np.second_pos_x = sat_pos(22'(fs.pair.second_pos_x) + sx);
      np.second_pos_y = sat_pos(22'(fs.pair.second_pos_y) + sy);
    end
    if (fs.imp) begin
      np.first_vel_x  = sat_vel(21'(fs.pair.first_vel_x) - ix);
      np.first_vel_y  = sat_vel(21'(fs.pair.first_vel_y) - iy);
      np.second_vel_x = sat_vel(21'(fs.pair.second_vel_x) + ix);
      np.second_vel_y = sat_vel(21'(fs.pair.second_vel_y) + iy);
    end
    res_data = {np.second_vel_y, np.second_vel_x, np.first_vel_y, np.first_vel_x,
                np.second_pos_y, np.second_pos_x, np.first_pos_y, np.first_pos_x};
    res_user = {fs.coin, fs.imp, fs.contact};
  end

  // ---------------- output register and skid stage ----------------
  logic [DATA_W-1:0] skid_data;
  logic [USER_W-1:0] skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= res_data;
        m_tuser <= res_user;
      end
    end else if (push) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

endmodule
